// File: hw/rtl/ptss_pkg.sv
// Package for the pan/tilt servo stepper: sizes, register map, command characters
// and the angle-to-pulse-width function. No dependencies.
`timescale 1ns / 1ps

package ptss_pkg;

   // Design constants
   localparam int ANGLE_MAX        = 180;
   localparam int IDLE_COUNT_WIDTH = 16;

   localparam int ANGLE_WIDTH   = 8;
   localparam int STEP_WIDTH    = 7;
   localparam int TIMEOUT_WIDTH = 16;
   localparam int PULSE_WIDTH   = 12;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam int RSP_FIELD_BITS = 2 * PULSE_WIDTH + 4;
   localparam int RSP_DATA_WIDTH = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_DATA_WIDTH = 8;

   localparam int PAN_RESET_DEG  = 90;
   localparam int TILT_NOMINAL   = 180;
   localparam int TILT_RESET_DEG = (TILT_NOMINAL > ANGLE_MAX) ? ANGLE_MAX : TILT_NOMINAL;

   localparam int STEP_RESET    = 2;
   localparam int TIMEOUT_RESET = 100;

   // Register indexes (byte address = 4 * index)
   localparam logic REG_STEP_SIZE     = 1'b0;
   localparam logic REG_TIMEOUT_TICKS = 1'b1;

   // Item kinds carried on tuser
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Movement characters
   localparam logic [7:0] CHAR_W_LO = 8'h77;
   localparam logic [7:0] CHAR_W_UP = 8'h57;
   localparam logic [7:0] CHAR_S_LO = 8'h73;
   localparam logic [7:0] CHAR_S_UP = 8'h53;
   localparam logic [7:0] CHAR_A_LO = 8'h61;
   localparam logic [7:0] CHAR_A_UP = 8'h41;
   localparam logic [7:0] CHAR_D_LO = 8'h64;
   localparam logic [7:0] CHAR_D_UP = 8'h44;

   // Pulse width = 500 + angle*2000/180 = 500 + floor(angle*100/9).
   // floor(x/9) = (x * 29128) >> 18, exact for x below 2^15.
   localparam int PULSE_BASE    = 500;
   localparam int PULSE_SHIFT   = 18;
   localparam int PULSE_RECIP   = 100 * 29128;
   localparam int PRODUCT_WIDTH = 30;

   typedef logic [ANGLE_WIDTH-1:0] angle_type;
   typedef logic [PULSE_WIDTH-1:0] pulse_type;

   function automatic pulse_type pulse_of(input angle_type angle);
      logic [PRODUCT_WIDTH-1:0] prod;
      logic [PULSE_WIDTH-1:0]   scaled;
      prod   = PRODUCT_WIDTH'(angle) * PRODUCT_WIDTH'(PULSE_RECIP);
      scaled = prod[PULSE_SHIFT +: PULSE_WIDTH];
      return PULSE_WIDTH'(PULSE_WIDTH'(PULSE_BASE) + scaled);
   endfunction

endpackage

// File: hw/rtl/pan_tilt_servo_stepper_top.sv
// Pan/tilt servo stepper top level: input register, angle/timeout update, result register
// and APB-style register port. Depends on ptss_pkg.
`timescale 1ns / 1ps

//  channel  | direction | handshake               | content
//  req_     | in        | tvalid/tready           | tdata: command_byte; tuser: func
//  rsp_     | out       | tvalid/tready           | tdata: pulses, active, restart bits
//  csr_     | in        | psel/penable/pready     | step_size @0x0, timeout_ticks @0x4
//
//  One beat per cycle sustained while rsp_ does not stall; a request beat passes through the
//  input register, then the result register. Angles and the idle counter update as a
//  beat moves from the input register into the result register. A stall on rsp_
//  holds both registers and drops req_tready once both are full. Synchronous reset
//  restores angles 90/180, both axes inactive, idle counter zero, registers to defaults.

module pan_tilt_servo_stepper_top (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: [7:0] command_byte
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptss_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // req_tuser: [0] func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: [11:0] pan_pulse_us, [23:12] tilt_pulse_us, [24] pan_active,
   //            [25] tilt_active, [26] pan_restart, [27] tilt_restart, [31:28] zero
   output logic [ptss_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ptss_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [ptss_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [ptss_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import ptss_pkg::*;

   localparam int CMP_WIDTH = (IDLE_COUNT_WIDTH > TIMEOUT_WIDTH) ? IDLE_COUNT_WIDTH
                                                                  : TIMEOUT_WIDTH;

   // Configuration
   logic [STEP_WIDTH-1:0]    step_size_ff;
   logic [TIMEOUT_WIDTH-1:0] timeout_ff;
   logic                     csr_write;
   logic                     csr_index;

   // Input register
   logic                    in_valid_ff, in_valid_in;
   logic                    in_func_ff;
   logic [7:0]              in_byte_ff;

   // Block state
   angle_type               pan_angle_ff, pan_angle_in;
   angle_type               tilt_angle_ff, tilt_angle_in;
   logic                    pan_on_ff, pan_on_in;
   logic                    tilt_on_ff, tilt_on_in;
   logic [IDLE_COUNT_WIDTH-1:0] idle_count_ff, idle_count_in;

   // Result register
   logic                       out_valid_ff, out_valid_in;
   logic [RSP_DATA_WIDTH-1:0]  out_data_ff, out_data_in;

   logic out_free;
   logic advance;
   logic req_take;

   logic tilt_up, tilt_down, pan_up, pan_down;
   logic pan_new, tilt_new;
   logic timed_out;

   function automatic angle_type raise_angle(input angle_type angle,
                                             input logic [STEP_WIDTH-1:0] step);
      logic [ANGLE_WIDTH:0] sum;
      sum = {1'b0, angle} + (ANGLE_WIDTH+1)'(step);
      return (sum > (ANGLE_WIDTH+1)'(ANGLE_MAX)) ? ANGLE_WIDTH'(ANGLE_MAX)
                                                  : sum[ANGLE_WIDTH-1:0];
   endfunction

   function automatic angle_type lower_angle(input angle_type angle,
                                             input logic [STEP_WIDTH-1:0] step);
      logic [ANGLE_WIDTH-1:0] wide_step;
      wide_step = ANGLE_WIDTH'(step);
      return (angle < wide_step) ? '0 : angle - wide_step;
   endfunction

   // Handshake: the result register frees up when empty or being taken
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      unique case (csr_index)
         REG_STEP_SIZE:     csr_prdata = CSR_DATA_WIDTH'(step_size_ff);
         REG_TIMEOUT_TICKS: csr_prdata = CSR_DATA_WIDTH'(timeout_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff <= STEP_WIDTH'(STEP_RESET);
         timeout_ff   <= TIMEOUT_WIDTH'(TIMEOUT_RESET);
      end else if (csr_write) begin
         if (csr_index == REG_STEP_SIZE) begin
            step_size_ff <= csr_pwdata[STEP_WIDTH-1:0];
         end else begin
            timeout_ff <= csr_pwdata[TIMEOUT_WIDTH-1:0];
         end
      end
   end

   // Command decode on the registered beat
   always_comb begin
      tilt_up   = (in_func_ff == FUNC_BYTE) && (in_byte_ff == CHAR_W_LO || in_byte_ff == CHAR_W_UP);
      tilt_down = (in_func_ff == FUNC_BYTE) && (in_byte_ff == CHAR_S_LO || in_byte_ff == CHAR_S_UP);
      pan_up    = (in_func_ff == FUNC_BYTE) && (in_byte_ff == CHAR_A_LO || in_byte_ff == CHAR_A_UP);
      pan_down  = (in_func_ff == FUNC_BYTE) && (in_byte_ff == CHAR_D_LO || in_byte_ff == CHAR_D_UP);
      tilt_new  = tilt_up || tilt_down;
      pan_new   = pan_up || pan_down;
   end

   // State update and result formation
   always_comb begin
      tilt_angle_in = tilt_angle_ff;
      pan_angle_in  = pan_angle_ff;
      if (tilt_up) begin
         tilt_angle_in = raise_angle(tilt_angle_ff, step_size_ff);
      end else if (tilt_down) begin
         tilt_angle_in = lower_angle(tilt_angle_ff, step_size_ff);
      end
      if (pan_up) begin
         pan_angle_in = raise_angle(pan_angle_ff, step_size_ff);
      end else if (pan_down) begin
         pan_angle_in = lower_angle(pan_angle_ff, step_size_ff);
      end

      // any byte clears the idle counter; ticks count up and stick at all ones
      if (in_func_ff == FUNC_BYTE) begin
         idle_count_in = '0;
      end else if (idle_count_ff != '1) begin
         idle_count_in = idle_count_ff + IDLE_COUNT_WIDTH'(1);
      end else begin
         idle_count_in = idle_count_ff;
      end

      timed_out  = CMP_WIDTH'(idle_count_in) >= CMP_WIDTH'(timeout_ff);
      pan_on_in  = (pan_on_ff || pan_new) && !timed_out;
      tilt_on_in = (tilt_on_ff || tilt_new) && !timed_out;

      out_data_in = RSP_DATA_WIDTH'({tilt_new, pan_new, tilt_on_in, pan_on_in,
                                     pulse_of(tilt_angle_in), pulse_of(pan_angle_in)});
   end

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pan_angle_ff  <= ANGLE_WIDTH'(PAN_RESET_DEG);
         tilt_angle_ff <= ANGLE_WIDTH'(TILT_RESET_DEG);
         pan_on_ff     <= 1'b0;
         tilt_on_ff    <= 1'b0;
         idle_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            pan_angle_ff  <= pan_angle_in;
            tilt_angle_ff <= tilt_angle_in;
            pan_on_ff     <= pan_on_in;
            tilt_on_ff    <= tilt_on_in;
            idle_count_ff <= idle_count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: hw/rtl/ptss_checker.sv
// Port-level checker for the pan/tilt servo stepper, bound to the top level.
// Depends on ptss_pkg and pan_tilt_servo_stepper_top.
`timescale 1ns / 1ps

module ptss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [ptss_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                                req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ptss_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import ptss_pkg::*;

   // no result beat is presented in the cycle right after a reset cycle
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // one command byte moves at most one axis
   a_one_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2*PULSE_WIDTH+2] && rsp_tdata[2*PULSE_WIDTH+3]))
      else $error("both restart bits set in one result");

   // pulse widths never fall below the zero-degree setting
   a_pulse_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PULSE_WIDTH-1:0] >= PULSE_WIDTH'(PULSE_BASE)
                  && rsp_tdata[2*PULSE_WIDTH-1:PULSE_WIDTH] >= PULSE_WIDTH'(PULSE_BASE))
      else $error("pulse width below base");

   // with the result register full and stalled, the input side must not take a beat
   // that would need a free slot beyond the input register
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && req_tvalid && req_tready |=> !req_tready || rsp_tready)
      else $error("input accepted beyond pipeline depth");

endmodule

bind pan_tilt_servo_stepper_top ptss_checker u_ptss_checker (.*);
